[design/psrc_pkg.sv]
package psrc_pkg;

	localparam int unsigned EXPECT_DEPTH_DEF = 8;
	localparam int unsigned QUEUED_MAX_DEF   = 255;

	localparam int unsigned HOLD_DEPTH = 7;

	localparam logic [7:0] ACK_HEAD0 = 8'h37;
	localparam logic [7:0] ACK_HEAD1 = 8'h22;
	localparam logic [7:0] ACK_TAIL  = 8'h00;
	localparam logic [7:0] FIX_MASK  = 8'h93;
	localparam logic [7:0] AUTO_BITS = 8'h10;
	localparam logic [7:0] RT_BITS   = 8'h12;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;

	typedef enum logic [1:0] {
		OP_BYTE   = 2'd0,
		OP_RT     = 2'd1,
		OP_QUEUED = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_ACK     = 3'd0,
		EV_AUTO    = 3'd1,
		EV_RT      = 3'd2,
		EV_QUEUED  = 3'd3,
		EV_UNKNOWN = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // take the input beat
		logic capture;   // latch one event, retire its bytes
		logic mark_last; // held event ends the run
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;      // an event is ready to be classified now
	} status_t;

endpackage

[design/psrc_ctrl.sv]
module psrc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  psrc_pkg::status_t sts,
	output psrc_pkg::cmd_t    cmd
);
	import psrc_pkg::*;

	state_t state_q, state_d;
	logic   has_pend_q, has_pend_d;
	logic   last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			has_pend_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			has_pend_q <= has_pend_d;
			last_q     <= last_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		has_pend_d    = has_pend_q;
		last_d        = last_q;
		cmd           = '0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.emit && !has_pend_q) begin
					cmd.capture = 1'b1;
					has_pend_d  = 1'b1;
				end else if (sts.emit) begin
					last_d  = 1'b0;
					state_d = ST_OUT;
				end else if (has_pend_q) begin
					cmd.mark_last = 1'b1;
					last_d        = 1'b1;
					state_d       = ST_OUT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					has_pend_d = 1'b0;
					state_d    = last_q ? ST_IDLE : ST_EVAL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_out_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> has_pend_q)
		else $error("beat offered with no event held");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !has_pend_q)
		else $error("input taken while an event is still held");

	a_no_double_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !cmd.capture)
		else $error("event captured over an undelivered one");

endmodule

[design/psrc_dp.sv]
module psrc_dp #(
	parameter int unsigned EXPECT_DEPTH = psrc_pkg::EXPECT_DEPTH_DEF,
	parameter int unsigned QUEUED_MAX   = psrc_pkg::QUEUED_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  psrc_pkg::cmd_t    cmd,
	output psrc_pkg::status_t sts,
	input  logic [1:0]        operation,
	input  logic [7:0]        data_byte,
	input  logic [1:0]        request_kind,
	output logic [2:0]        event_kind,
	output logic [31:0]       ack_token,
	output logic [31:0]       status_frame,
	output logic [7:0]        single_byte,
	output logic [1:0]        answered_kind,
	output logic [11:0]       flag_values,
	output logic [11:0]       flag_valid,
	output logic              last_of_run
);
	import psrc_pkg::*;

	localparam int unsigned CW = $clog2(EXPECT_DEPTH + 1);
	localparam int unsigned QW = $clog2(QUEUED_MAX + 1);

	logic [7:0]    held_q [HOLD_DEPTH];
	logic [2:0]    held_cnt_q;
	logic [1:0]    exp_q [EXPECT_DEPTH];
	logic [CW-1:0] exp_cnt_q;
	logic [QW-1:0] pend_q;
	logic          force_q;

	function automatic logic printable(input logic [7:0] b);
		printable = (b >= PRINT_LO) && (b <= PRINT_HI);
	endfunction

	function automatic logic [23:0] decode_rt(input logic [1:0] k, input logic [7:0] v);
		logic [11:0] f;
		logic [11:0] m;
		f = '0;
		m = '0;
		case (k)
			2'd0: begin
				f = {8'd0, v[6], v[5], ~v[3], v[2]};
				m = 12'h00F;
			end
			2'd1: begin
				f = {v[5], 4'd0, v[6], v[3], v[2], 4'd0};
				m = 12'h870;
			end
			2'd2: begin
				f = {2'd0, v[6], v[5], v[3], 7'd0};
				m = 12'h380;
			end
			default: begin
				f = {v[5], v[2], 10'd0};
				m = 12'hC00;
			end
		endcase
		decode_rt = {f, m};
	endfunction

	// classification of the held bytes
	logic        first_ack, first_auto, bad_ack, bad_auto;
	logic        ack_emit, ack_hold, auto_emit, auto_hold, lone;
	logic        is_rt, is_q;
	logic [23:0] rt_dec;
	logic [11:0] auto_flags;

	always_comb begin
		first_ack  = (held_cnt_q != 3'd0) && (held_q[0] == ACK_HEAD0);
		first_auto = (held_cnt_q != 3'd0) && ((held_q[0] & FIX_MASK) == AUTO_BITS);
		bad_ack    = (held_cnt_q >= 3'd2) && (held_q[1] != ACK_HEAD1);
		for (int i = 2; i < 6; i++) begin
			if ((held_cnt_q > 3'(i)) && !printable(held_q[i]))
				bad_ack = 1'b1;
		end
		if ((held_cnt_q == 3'd7) && (held_q[6] != ACK_TAIL))
			bad_ack = 1'b1;
		bad_auto = 1'b0;
		for (int i = 1; i < 4; i++) begin
			if ((held_cnt_q > 3'(i)) && ((held_q[i] & FIX_MASK) != AUTO_BITS))
				bad_auto = 1'b1;
		end
		ack_emit  = first_ack && !bad_ack && (held_cnt_q == 3'd7);
		ack_hold  = first_ack && !bad_ack && (held_cnt_q != 3'd7) && !force_q;
		auto_emit = first_auto && !bad_auto && (held_cnt_q >= 3'd4);
		auto_hold = first_auto && !bad_auto && (held_cnt_q < 3'd4) && !force_q;
		lone      = (held_cnt_q != 3'd0) && !ack_emit && !ack_hold && !auto_emit && !auto_hold;
		is_rt     = (exp_cnt_q != '0) && ((held_q[0] & FIX_MASK) == RT_BITS);
		is_q      = !is_rt && (pend_q != '0);
		rt_dec    = decode_rt(exp_q[0], held_q[0]);
		auto_flags = {held_q[3][5], held_q[3][2], held_q[2][6], held_q[2][5], held_q[2][3],
			held_q[1][6], held_q[1][3], held_q[1][2], held_q[0][6], held_q[0][5],
			~held_q[0][3], held_q[0][2]};
	end

	assign sts.emit = ack_emit || auto_emit || lone;

	logic do_pop, do_push;
	assign do_pop  = cmd.capture && lone && is_rt;
	assign do_push = cmd.load && (op_t'(operation) == OP_RT) &&
		(exp_cnt_q < CW'(EXPECT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			exp_cnt_q  <= '0;
			pend_q     <= '0;
			force_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				force_q <= (op_t'(operation) == OP_FLUSH);
				case (op_t'(operation))
					OP_BYTE: begin
						if (held_cnt_q < 3'd7)
							held_cnt_q <= held_cnt_q + 3'd1;
					end
					OP_RT: begin
						if (do_push)
							exp_cnt_q <= exp_cnt_q + CW'(1);
					end
					OP_QUEUED: begin
						if (pend_q < QW'(QUEUED_MAX))
							pend_q <= pend_q + QW'(1);
					end
					default: begin
					end
				endcase
			end else if (cmd.capture) begin
				if (ack_emit)
					held_cnt_q <= '0;
				else if (auto_emit)
					held_cnt_q <= held_cnt_q - 3'd4;
				else
					held_cnt_q <= held_cnt_q - 3'd1;
				if (do_pop)
					exp_cnt_q <= exp_cnt_q - CW'(1);
				if (lone && is_q)
					pend_q <= pend_q - QW'(1);
			end
		end
	end

	// hold buffer
	always_ff @(posedge clk) begin
		if (cmd.load && (op_t'(operation) == OP_BYTE) && (held_cnt_q < 3'd7)) begin
			held_q[held_cnt_q] <= data_byte;
		end else if (cmd.capture && auto_emit) begin
			for (int i = 0; i < 3; i++)
				held_q[i] <= held_q[i + 4];
		end else if (cmd.capture && lone) begin
			for (int i = 0; i < 6; i++)
				held_q[i] <= held_q[i + 1];
		end
	end

	// expectation queue, head at entry 0
	always_ff @(posedge clk) begin
		if (do_push) begin
			for (int i = 0; i < EXPECT_DEPTH; i++)
				if (exp_cnt_q == CW'(i))
					exp_q[i] <= request_kind;
		end else if (do_pop) begin
			for (int i = 0; i < EXPECT_DEPTH - 1; i++)
				exp_q[i] <= exp_q[i + 1];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ack_token     <= '0;
			status_frame  <= '0;
			single_byte   <= '0;
			answered_kind <= '0;
			flag_values   <= '0;
			flag_valid    <= '0;
			last_of_run   <= 1'b0;
			if (ack_emit) begin
				event_kind <= EV_ACK;
				ack_token  <= {held_q[2], held_q[3], held_q[4], held_q[5]};
			end else if (auto_emit) begin
				event_kind   <= EV_AUTO;
				status_frame <= {held_q[0], held_q[1], held_q[2], held_q[3]};
				flag_values  <= auto_flags;
				flag_valid   <= 12'hFFF;
			end else begin
				single_byte <= held_q[0];
				if (is_rt) begin
					event_kind    <= EV_RT;
					answered_kind <= exp_q[0];
					flag_values   <= rt_dec[23:12];
					flag_valid    <= rt_dec[11:0];
				end else if (is_q) begin
					event_kind <= EV_QUEUED;
				end else begin
					event_kind <= EV_UNKNOWN;
				end
			end
		end else if (cmd.mark_last) begin
			last_of_run <= 1'b1;
		end
	end

endmodule

[design/printer_status_response_classifier_top.sv]
// channel | signals                                        | beat taken when
// --------+------------------------------------------------+--------------------
// in      | operation, data_byte, request_kind             | in_valid & in_ready
// out     | event_kind, ack_token, status_frame,           | out_valid & out_ready
//         | single_byte, answered_kind, flag_values,       |
//         | flag_valid, last_of_run                        |
//
// One input beat per run: a load step, then for each event a capture step, a look-ahead
// step and an output state.
// Up to 7 events per run, one classify step of the hold buffer per event.
// in_ready is high only in idle, so the next input waits for the run to finish.
// out_valid holds with its payload until out_ready; the run stalls meanwhile.
// arst_n clears counts and control; buffer contents need no reset.
module printer_status_response_classifier_top #(
	parameter int unsigned EXPECT_DEPTH = psrc_pkg::EXPECT_DEPTH_DEF,
	parameter int unsigned QUEUED_MAX   = psrc_pkg::QUEUED_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic [1:0]  request_kind,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [31:0] ack_token,
	output logic [31:0] status_frame,
	output logic [7:0]  single_byte,
	output logic [1:0]  answered_kind,
	output logic [11:0] flag_values,
	output logic [11:0] flag_valid,
	output logic        last_of_run
);
	import psrc_pkg::*;

	cmd_t    cmd;
	status_t sts;

	psrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	psrc_dp #(
		.EXPECT_DEPTH (EXPECT_DEPTH),
		.QUEUED_MAX   (QUEUED_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.data_byte     (data_byte),
		.request_kind  (request_kind),
		.event_kind    (event_kind),
		.ack_token     (ack_token),
		.status_frame  (status_frame),
		.single_byte   (single_byte),
		.answered_kind (answered_kind),
		.flag_values   (flag_values),
		.flag_valid    (flag_valid),
		.last_of_run   (last_of_run)
	);

endmodule

[bench/tb_top.sv]
module tb_top;
	import psrc_pkg::*;

	localparam int unsigned EXPECT_DEPTH   = EXPECT_DEPTH_DEF;
	localparam int unsigned QUEUED_MAX     = QUEUED_MAX_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		op_t        op;
		logic [7:0] data;
		logic [1:0] kind;
	} stim_item_t;

	typedef struct {
		event_t      kind;
		logic [31:0] ack_token;
		logic [31:0] status_frame;
		logic [7:0]  single_byte;
		logic [1:0]  answered_kind;
		logic [11:0] flag_values;
		logic [11:0] flag_valid;
		logic        last_of_run;
	} status_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic [1:0]  request_kind = 2'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [31:0] ack_token;
	logic [31:0] status_frame;
	logic [7:0]  single_byte;
	logic [1:0]  answered_kind;
	logic [11:0] flag_values;
	logic [11:0] flag_valid;
	logic        last_of_run;

	stim_item_t    pending_items [$];
	status_event_t expected_events [$];

	// mirror of the block state
	logic [7:0]  held_bytes [$];
	logic [1:0]  rt_kinds [$];
	int unsigned queued_owed = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	bit          in_beat = 1'b0;
	bit          out_beat = 1'b0;

	printer_status_response_classifier_top #(
		.EXPECT_DEPTH(EXPECT_DEPTH),
		.QUEUED_MAX(QUEUED_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.data_byte(data_byte),
		.request_kind(request_kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.ack_token(ack_token),
		.status_frame(status_frame),
		.single_byte(single_byte),
		.answered_kind(answered_kind),
		.flag_values(flag_values),
		.flag_valid(flag_valid),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Classifies the head of the hold buffer; returns 0 when it must wait for more bytes.
	function automatic bit classify_next(input bit flush_all, output status_event_t ev);
		logic [7:0] b0, b1, b2, b3;
		logic [1:0] k;
		int         avail;
		bit         bad;
		ev.kind          = EV_UNKNOWN;
		ev.ack_token     = '0;
		ev.status_frame  = '0;
		ev.single_byte   = '0;
		ev.answered_kind = '0;
		ev.flag_values   = '0;
		ev.flag_valid    = '0;
		ev.last_of_run   = 1'b0;
		if (held_bytes.size() == 0)
			return 1'b0;
		avail = held_bytes.size();
		b0 = held_bytes[0];

		if (b0 == ACK_HEAD0) begin
			bad = avail >= 2 && held_bytes[1] != ACK_HEAD1;
			for (int i = 2; !bad && i < avail && i < 6; i++)
				bad = held_bytes[i] < PRINT_LO || held_bytes[i] > PRINT_HI;
			if (!bad && avail == 7 && held_bytes[6] != ACK_TAIL)
				bad = 1'b1;
			if (!bad) begin
				if (avail >= 7) begin
					ev.kind = EV_ACK;
					ev.ack_token = {held_bytes[2], held_bytes[3], held_bytes[4], held_bytes[5]};
					repeat (7) held_bytes.delete(0);
					return 1'b1;
				end
				if (!flush_all)
					return 1'b0;
			end
		end

		if ((b0 & FIX_MASK) == AUTO_BITS) begin
			bad = 1'b0;
			for (int i = 1; !bad && i < avail && i < 4; i++)
				bad = (held_bytes[i] & FIX_MASK) != AUTO_BITS;
			if (!bad) begin
				if (avail >= 4) begin
					b1 = held_bytes[1];
					b2 = held_bytes[2];
					b3 = held_bytes[3];
					ev.kind = EV_AUTO;
					ev.status_frame = {b0, b1, b2, b3};
					ev.flag_values = {b3[5], b3[2], b2[6], b2[5], b2[3], b1[6], b1[3], b1[2],
						b0[6], b0[5], ~b0[3], b0[2]};
					ev.flag_valid = 12'hFFF;
					repeat (4) held_bytes.delete(0);
					return 1'b1;
				end
				if (!flush_all)
					return 1'b0;
			end
		end

		ev.single_byte = b0;
		if (rt_kinds.size() > 0 && (b0 & FIX_MASK) == RT_BITS) begin
			k = rt_kinds[0];
			rt_kinds.delete(0);
			ev.kind = EV_RT;
			ev.answered_kind = k;
			case (k)
				2'd0: begin
					ev.flag_values = {8'b0, b0[6], b0[5], ~b0[3], b0[2]};
					ev.flag_valid = 12'h00F;
				end
				2'd1: begin
					ev.flag_values = {b0[5], 4'b0, b0[6], b0[3], b0[2], 4'b0};
					ev.flag_valid = 12'h870;
				end
				2'd2: begin
					ev.flag_values = {2'b0, b0[6], b0[5], b0[3], 7'b0};
					ev.flag_valid = 12'h380;
				end
				default: begin
					ev.flag_values = {b0[5], b0[2], 10'b0};
					ev.flag_valid = 12'hC00;
				end
			endcase
		end else if (queued_owed > 0) begin
			queued_owed--;
			ev.kind = EV_QUEUED;
		end else begin
			ev.kind = EV_UNKNOWN;
		end
		held_bytes.delete(0);
		return 1'b1;
	endfunction

	task automatic drain_held(input bit flush_all);
		status_event_t ev;
		status_event_t run_events [$];
		while (run_events.size() < HOLD_DEPTH && classify_next(flush_all, ev))
			run_events.insert(run_events.size(), ev);
		if (run_events.size() > 0)
			run_events[run_events.size() - 1].last_of_run = 1'b1;
		foreach (run_events[i])
			expected_events.insert(expected_events.size(), run_events[i]);
	endtask

	task automatic predict_item(input stim_item_t it);
		case (it.op)
			OP_BYTE: begin
				if (held_bytes.size() < HOLD_DEPTH)
					held_bytes.insert(held_bytes.size(), it.data);
				drain_held(1'b0);
			end
			OP_RT: begin
				if (rt_kinds.size() < EXPECT_DEPTH)
					rt_kinds.insert(rt_kinds.size(), it.kind);
			end
			OP_QUEUED: begin
				if (queued_owed < QUEUED_MAX)
					queued_owed++;
			end
			default: drain_held(1'b1);
		endcase
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		status_event_t want;
		in_beat = arst_n && in_valid && in_ready;
		out_beat = arst_n && out_valid && out_ready;
		if (in_beat)
			predict_item(stim_item_t'{op_t'(operation), data_byte, request_kind});
		if (out_beat) begin
			if (expected_events.size() == 0) begin
				$error("output beat with no event expected, event_kind %0d", event_kind);
				mismatches++;
			end else begin
				want = expected_events[0];
				expected_events.delete(0);
				check_field("event_kind", 32'(want.kind), 32'(event_kind));
				check_field("ack_token", want.ack_token, ack_token);
				check_field("status_frame", want.status_frame, status_frame);
				check_field("single_byte", 32'(want.single_byte), 32'(single_byte));
				check_field("answered_kind", 32'(want.answered_kind), 32'(answered_kind));
				check_field("flag_values", 32'(want.flag_values), 32'(flag_values));
				check_field("flag_valid", 32'(want.flag_valid), 32'(flag_valid));
				check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
			end
		end
		if (in_beat || out_beat || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		stim_item_t it;
		if (arst_n && (!in_valid || in_beat)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items[0];
				pending_items.delete(0);
				in_valid <= 1'b1;
				operation <= it.op;
				data_byte <= it.data;
				request_kind <= it.kind;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && $urandom_range(99) >= recv_stall_pct;
	end

	task automatic push_item(input op_t op, input logic [7:0] b, input logic [1:0] k);
		pending_items.insert(pending_items.size(), stim_item_t'{op, b, k});
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(OP_BYTE, b, 2'($urandom));
	endtask

	task automatic push_flush();
		push_item(OP_FLUSH, 8'($urandom), 2'($urandom));
	endtask

	// Mostly well-formed frames and query/answer pairs, with broken frames and noise.
	task automatic add_traffic(input int unsigned n_items);
		logic [7:0]  frame [7];
		logic [7:0]  b;
		int unsigned start, cut, len, nk;
		start = pending_items.size();
		while (pending_items.size() - start < n_items) begin
			frame[0] = ACK_HEAD0;
			frame[1] = ACK_HEAD1;
			for (int i = 2; i < 6; i++)
				frame[i] = 8'($urandom_range(PRINT_LO, PRINT_HI));
			frame[6] = ACK_TAIL;
			case ($urandom_range(99)) inside
				[0:17]: foreach (frame[i]) push_byte(frame[i]);
				[18:29]: begin
					cut = $urandom_range(1, 6);
					if ($urandom_range(2) != 0) begin
						b = 8'($urandom);
						if (cut == 1) begin
							if (b == ACK_HEAD1)
								b ^= 8'h01;
						end else if (cut == 6) begin
							if (b == ACK_TAIL)
								b = 8'($urandom_range(1, 255));
						end else if (b >= PRINT_LO && b <= PRINT_HI) begin
							b = $urandom_range(1) ? 8'($urandom_range(0, 8'h1F))
								: 8'($urandom_range(8'h7F, 8'hFF));
						end
						frame[cut] = b;
						for (int i = 0; i <= cut; i++)
							push_byte(frame[i]);
					end else begin
						for (int i = 0; i < cut; i++)
							push_byte(frame[i]);
						push_flush();
					end
				end
				[30:43]: repeat (4) push_byte((8'($urandom) & ~FIX_MASK) | AUTO_BITS);
				[44:51]: begin
					len = $urandom_range(1, 3);
					repeat (len) push_byte((8'($urandom) & ~FIX_MASK) | AUTO_BITS);
					if ($urandom_range(1)) begin
						push_flush();
					end else begin
						b = 8'($urandom);
						if ((b & FIX_MASK) == AUTO_BITS)
							b ^= 8'h80;
						push_byte(b);
					end
				end
				[52:63]: begin
					nk = $urandom_range(1, EXPECT_DEPTH + 2);
					repeat (nk) push_item(OP_RT, 8'($urandom), 2'($urandom));
					repeat ($urandom_range(1, nk))
						push_byte((8'($urandom) & ~FIX_MASK) | RT_BITS);
				end
				[64:71]: begin
					push_item(OP_QUEUED, 8'($urandom), 2'($urandom));
					push_byte(8'($urandom));
				end
				[72:79]: push_flush();
				default: push_item(op_t'($urandom_range(3)), 8'($urandom), 2'($urandom));
			endcase
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (!(pending_items.size() == 0 && !in_valid && expected_events.size() == 0
			&& in_ready));
	endtask

	initial begin
		logic [7:0] good_ack [7];
		logic [7:0] bad_ack [7];
		good_ack = '{8'h37, 8'h22, 8'h20, 8'h7E, 8'h41, 8'h5A, 8'h00};
		bad_ack  = '{8'h37, 8'h22, 8'h41, 8'h42, 8'h43, 8'h44, 8'h01};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_byte(8'hFF);
		push_flush();
		push_item(OP_QUEUED, 8'h00, 2'd3);
		push_byte(8'h55);
		push_item(OP_RT, 8'hFF, 2'd0);
		push_item(OP_RT, 8'h00, 2'd3);
		push_byte(8'h12);
		push_byte(8'h7E);
		foreach (good_ack[i]) push_byte(good_ack[i]);
		foreach (bad_ack[i]) push_byte(bad_ack[i]);
		push_byte(AUTO_BITS);
		push_byte(8'h14);
		push_flush();
		add_traffic(95);
		wait_drained();

		send_idle_pct = 46;
		recv_stall_pct = 0;
		add_traffic(95);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 46;
		add_traffic(95);
		wait_drained();

		send_idle_pct = 37;
		recv_stall_pct = 37;
		add_traffic(95);
		wait_drained();

		repeat (20) @(posedge clk);
		if (expected_events.size() != 0) begin
			$error("%0d expected events never arrived", expected_events.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule

[sim.f]
design/psrc_pkg.sv
design/psrc_ctrl.sv
design/psrc_dp.sv
design/printer_status_response_classifier_top.sv
bench/tb_top.sv
